FILE: hdl/hpst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_pkg: shared types and constants for the hall period stability tracker
// Register indexes, reset values, divider request/response and FSM states.
// ----------------------------------------------------------------------------
package hpst_pkg;

    localparam int DIV_W = 40;
    localparam int CNT_W = 6;

    typedef logic [2:0] cfg_idx_t;

    localparam cfg_idx_t REG_TICKS_PER_MICRO  = 3'd0;
    localparam cfg_idx_t REG_STABLE_PERCENT   = 3'd1;
    localparam cfg_idx_t REG_CONFIRM_NEEDED   = 3'd2;
    localparam cfg_idx_t REG_UNSTABLE_PERCENT = 3'd3;
    localparam cfg_idx_t REG_ANGLE_SLICES     = 3'd4;

    localparam logic [15:0] TPM_RESET       = 16'd240;
    localparam logic [7:0]  STABLE_RESET    = 8'd2;
    localparam logic [7:0]  CONFIRM_RESET   = 8'd5;
    localparam logic [7:0]  UNSTABLE_RESET  = 8'd10;
    localparam logic [15:0] SLICES_RESET    = 16'd256;

    localparam logic [31:0] SLICE_RESET     = 32'd1000;
    localparam logic [25:0] RPM_NUMERATOR   = 26'd60000000;
    localparam logic [15:0] RPM_MAX         = 16'hFFFF;
    localparam logic [8:0]  PCT_MAX         = 9'd200;

    // divider step counts; numerators are left-aligned in the DIV_W word
    localparam logic [CNT_W-1:0] ITER_PERIOD = 6'd32;
    localparam logic [CNT_W-1:0] ITER_PCT    = 6'd40;
    localparam logic [CNT_W-1:0] ITER_SLICE  = 6'd32;
    localparam logic [CNT_W-1:0] ITER_RPM    = 6'd26;

    typedef struct packed {
        logic [15:0] tpm;          // zero mapped to one
        logic [7:0]  stable_pct;
        logic [7:0]  confirm_needed;
        logic [7:0]  unstable_pct;
        logic [15:0] slices;       // zero mapped to one
    } cfg_regs_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [31:0]      den;
        logic [CNT_W-1:0] iters;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PERIOD,
        ST_DIFF,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_PCT,
        ST_DECIDE,
        ST_SLICE,
        ST_RPM_START,
        ST_RPM,
        ST_OUT
    } state_t;

endpackage

FILE: hdl/hpst_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_cfg: configuration register file
// Five setup registers written by index; zero divisors are mapped to one.
// ----------------------------------------------------------------------------
module hpst_cfg
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  hpst_pkg::cfg_idx_t   cfg_index,
    input  logic [15:0]          cfg_data,
    output hpst_pkg::cfg_regs_t  regs
);

    logic [15:0] tpm_reg;
    logic [7:0]  stable_reg;
    logic [7:0]  confirm_reg;
    logic [7:0]  unstable_reg;
    logic [15:0] slices_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg      <= hpst_pkg::TPM_RESET;
            stable_reg   <= hpst_pkg::STABLE_RESET;
            confirm_reg  <= hpst_pkg::CONFIRM_RESET;
            unstable_reg <= hpst_pkg::UNSTABLE_RESET;
            slices_reg   <= hpst_pkg::SLICES_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hpst_pkg::REG_TICKS_PER_MICRO:  tpm_reg      <= cfg_data;
                hpst_pkg::REG_STABLE_PERCENT:   stable_reg   <= cfg_data[7:0];
                hpst_pkg::REG_CONFIRM_NEEDED:   confirm_reg  <= cfg_data[7:0];
                hpst_pkg::REG_UNSTABLE_PERCENT: unstable_reg <= cfg_data[7:0];
                hpst_pkg::REG_ANGLE_SLICES:     slices_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        regs.tpm            = (tpm_reg == 16'd0) ? 16'd1 : tpm_reg;
        regs.stable_pct     = stable_reg;
        regs.confirm_needed = confirm_reg;
        regs.unstable_pct   = unstable_reg;
        regs.slices         = (slices_reg == 16'd0) ? 16'd1 : slices_reg;
    end

endmodule

FILE: hdl/hpst_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpst_div: shared restoring divider
// One quotient bit per cycle; numerator is left-aligned, iters sets the steps.
// ----------------------------------------------------------------------------
module hpst_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  hpst_pkg::div_req_t  req,
    output hpst_pkg::div_rsp_t  rsp
);

    logic                          busy_reg;
    logic                          busy_next;
    logic                          done_reg;
    logic                          done_next;
    logic [hpst_pkg::CNT_W-1:0]    cnt_reg;
    logic [hpst_pkg::CNT_W-1:0]    cnt_next;
    logic [31:0]                   rem_reg;
    logic [31:0]                   rem_next;
    logic [hpst_pkg::DIV_W-1:0]    numq_reg;
    logic [hpst_pkg::DIV_W-1:0]    numq_next;
    logic [31:0]                   den_reg;
    logic [31:0]                   den_next;

    logic [32:0] shifted;
    logic [33:0] trial;
    logic        fits;

    // remainder stays below the divisor, so it fits in 32 bits
    assign shifted = {rem_reg, numq_reg[hpst_pkg::DIV_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = ~trial[33];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        numq_next = numq_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = 32'd0;
            numq_next = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? trial[31:0] : shifted[31:0];
            numq_next = {numq_reg[hpst_pkg::DIV_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        numq_reg <= numq_next;
        den_reg  <= den_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = numq_reg;

endmodule

FILE: hdl/hall_period_stability_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hall_period_stability_tracker: hall-edge tachometer with stability tracking
// Converts timer captures to period, speed, change percent and slice time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / timer_count) takes one timer capture
//   per hall edge. in_stall is high while a word is being worked on.
//   Output channel (out_valid / out_stall / result fields) gives one result
//   word per input word; a held result does not block the next input.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the
//   five setup registers; cfg_ready is always high. Write only while idle.
// Sequencing:
//   First edge after reset (calibration): goes straight to the output step.
//   Later edges: paced by the shared one-bit-per-cycle divider (32 quotient
//   bits period, 40 percent, 32 slice when stable, 26 speed) plus the
//   sequencer steps. A zero mean or a zero period skips its divide.
//   One word in flight at a time; the next is taken once the sequencer is
//   back in idle after output.
// Reset clears the tracking state and sets the slice time to its reset value;
// setup registers return to defaults. If out_stall holds a result, the next
// word waits in the final step until the output register frees up.
// ----------------------------------------------------------------------------
module hall_period_stability_tracker
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] timer_count,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] period_micros,
    output logic [31:0] slice_micros,
    output logic        is_stable,
    output logic [15:0] speed_rpm,
    output logic [7:0]  change_percent,
    output logic        calibrating,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    hpst_pkg::cfg_regs_t cfg;
    hpst_pkg::div_req_t  div_req;
    hpst_pkg::div_rsp_t  div_rsp;

    hpst_pkg::state_t state_reg;
    hpst_pkg::state_t state_next;

    logic [31:0] last_ts_reg,  last_ts_next;
    logic [31:0] prev_reg,     prev_next;
    logic [31:0] cur_reg,      cur_next;
    logic [31:0] slice_reg,    slice_next;
    logic        stable_reg,   stable_next;
    logic [7:0]  confirm_reg,  confirm_next;
    logic        first_reg,    first_next;
    logic [15:0] rpm_reg,      rpm_next;
    logic [8:0]  pct_reg,      pct_next;
    logic        calib_reg,    calib_next;

    logic [31:0] prev_eff_reg, prev_eff_next;
    logic [31:0] diff_reg,     diff_next;
    logic [31:0] mean_reg,     mean_next;
    logic [39:0] acc_reg,      acc_next;

    logic        out_valid_reg,  out_valid_next;
    logic [31:0] out_period_reg, out_period_next;
    logic [31:0] out_slice_reg,  out_slice_next;
    logic        out_stable_reg, out_stable_next;
    logic [15:0] out_rpm_reg,    out_rpm_next;
    logic [7:0]  out_pct_reg,    out_pct_next;
    logic        out_calib_reg,  out_calib_next;

    logic        out_free;
    logic [32:0] sum33;
    logic [32:0] sub33;
    logic [31:0] abs_diff;
    logic [31:0] mean_val;
    logic [7:0]  conf_inc;
    logic        dec_stable;
    logic [7:0]  dec_count;

    hpst_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .regs      (cfg)
    );

    hpst_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall = (state_reg != hpst_pkg::ST_IDLE);
    assign out_free = ~out_valid_reg | ~out_stall;

    // mean uses the 33-bit sum
    assign sum33    = {1'b0, cur_reg} + {1'b0, prev_eff_reg};
    assign sub33    = {1'b0, cur_reg} - {1'b0, prev_eff_reg};
    assign abs_diff = sub33[32] ? (32'd0 - sub33[31:0]) : sub33[31:0];
    assign mean_val = sum33[32:1];

    // stability decision on the unsaturated percent
    always_comb
    begin
        conf_inc   = (confirm_reg < cfg.confirm_needed) ? (confirm_reg + 8'd1) : confirm_reg;
        dec_stable = stable_reg;
        dec_count  = confirm_reg;
        if (pct_reg <= {1'b0, cfg.stable_pct})
        begin
            dec_count = conf_inc;
            if (conf_inc >= cfg.confirm_needed)
            begin
                dec_stable = 1'b1;
            end
        end
        else if (pct_reg > {1'b0, cfg.unstable_pct})
        begin
            dec_stable = 1'b0;
            dec_count  = 8'd0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hpst_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = first_reg ? hpst_pkg::ST_OUT : hpst_pkg::ST_PERIOD;
                end
            end
            hpst_pkg::ST_PERIOD:
            begin
                if (div_rsp.done)
                begin
                    state_next = hpst_pkg::ST_DIFF;
                end
            end
            hpst_pkg::ST_DIFF:
            begin
                state_next = (mean_val == 32'd0) ? hpst_pkg::ST_DECIDE : hpst_pkg::ST_MUL1;
            end
            hpst_pkg::ST_MUL1: state_next = hpst_pkg::ST_MUL2;
            hpst_pkg::ST_MUL2: state_next = hpst_pkg::ST_MUL3;
            hpst_pkg::ST_MUL3: state_next = hpst_pkg::ST_PCT;
            hpst_pkg::ST_PCT:
            begin
                if (div_rsp.done)
                begin
                    state_next = hpst_pkg::ST_DECIDE;
                end
            end
            hpst_pkg::ST_DECIDE:
            begin
                state_next = (dec_stable && cur_reg != 32'd0) ? hpst_pkg::ST_SLICE
                                                              : hpst_pkg::ST_RPM_START;
            end
            hpst_pkg::ST_SLICE:
            begin
                if (div_rsp.done)
                begin
                    state_next = hpst_pkg::ST_RPM_START;
                end
            end
            hpst_pkg::ST_RPM_START:
            begin
                state_next = (cur_reg == 32'd0) ? hpst_pkg::ST_OUT : hpst_pkg::ST_RPM;
            end
            hpst_pkg::ST_RPM:
            begin
                if (div_rsp.done)
                begin
                    state_next = hpst_pkg::ST_OUT;
                end
            end
            hpst_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = hpst_pkg::ST_IDLE;
                end
            end
            default: state_next = hpst_pkg::ST_IDLE;
        endcase
    end

    // datapath and divider requests
    always_comb
    begin
        last_ts_next  = last_ts_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        slice_next    = slice_reg;
        stable_next   = stable_reg;
        confirm_next  = confirm_reg;
        first_next    = first_reg;
        rpm_next      = rpm_reg;
        pct_next      = pct_reg;
        calib_next    = calib_reg;
        prev_eff_next = prev_eff_reg;
        diff_next     = diff_reg;
        mean_next     = mean_reg;
        acc_next      = acc_reg;

        out_valid_next  = out_valid_reg & out_stall;
        out_period_next = out_period_reg;
        out_slice_next  = out_slice_reg;
        out_stable_next = out_stable_reg;
        out_rpm_next    = out_rpm_reg;
        out_pct_next    = out_pct_reg;
        out_calib_next  = out_calib_reg;

        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = 32'd0;
        div_req.iters = '0;

        case (state_reg)
            hpst_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    last_ts_next = timer_count;
                    pct_next     = 9'd0;
                    if (first_reg)
                    begin
                        first_next = 1'b0;
                        calib_next = 1'b1;
                    end
                    else
                    begin
                        calib_next    = 1'b0;
                        div_req.start = 1'b1;
                        div_req.num   = {timer_count - last_ts_reg, 8'd0};
                        div_req.den   = {16'd0, cfg.tpm};
                        div_req.iters = hpst_pkg::ITER_PERIOD;
                    end
                end
            end
            hpst_pkg::ST_PERIOD:
            begin
                if (div_rsp.done)
                begin
                    cur_next      = div_rsp.quot[31:0];
                    prev_eff_next = (prev_reg == 32'd0) ? div_rsp.quot[31:0] : prev_reg;
                end
            end
            hpst_pkg::ST_DIFF:
            begin
                diff_next = abs_diff;
                mean_next = mean_val;
                prev_next = cur_reg;
            end
            hpst_pkg::ST_MUL1:
            begin
                // diff * 100 = diff*64 + diff*32 + diff*4
                acc_next = ({8'd0, diff_reg} << 6) + ({8'd0, diff_reg} << 5);
            end
            hpst_pkg::ST_MUL2:
            begin
                acc_next = acc_reg + ({8'd0, diff_reg} << 2);
            end
            hpst_pkg::ST_MUL3:
            begin
                div_req.start = 1'b1;
                div_req.num   = acc_reg + {9'd0, mean_reg[31:1]};
                div_req.den   = mean_reg;
                div_req.iters = hpst_pkg::ITER_PCT;
            end
            hpst_pkg::ST_PCT:
            begin
                // quotient never exceeds 300 since diff <= 2*mean + 1
                if (div_rsp.done)
                begin
                    pct_next = div_rsp.quot[8:0];
                end
            end
            hpst_pkg::ST_DECIDE:
            begin
                stable_next  = dec_stable;
                confirm_next = dec_count;
                if (dec_stable && cur_reg != 32'd0)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {cur_reg, 8'd0};
                    div_req.den   = {16'd0, cfg.slices};
                    div_req.iters = hpst_pkg::ITER_SLICE;
                end
            end
            hpst_pkg::ST_SLICE:
            begin
                if (div_rsp.done)
                begin
                    slice_next = (div_rsp.quot[31:0] == 32'd0) ? 32'd1 : div_rsp.quot[31:0];
                end
            end
            hpst_pkg::ST_RPM_START:
            begin
                if (cur_reg == 32'd0)
                begin
                    rpm_next = 16'd0;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {hpst_pkg::RPM_NUMERATOR, 14'd0};
                    div_req.den   = cur_reg;
                    div_req.iters = hpst_pkg::ITER_RPM;
                end
            end
            hpst_pkg::ST_RPM:
            begin
                if (div_rsp.done)
                begin
                    rpm_next = (div_rsp.quot[25:16] != 10'd0) ? hpst_pkg::RPM_MAX
                                                              : div_rsp.quot[15:0];
                end
            end
            hpst_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_period_next = cur_reg;
                    out_slice_next  = slice_reg;
                    out_stable_next = stable_reg;
                    out_rpm_next    = rpm_reg;
                    out_pct_next    = (pct_reg > hpst_pkg::PCT_MAX) ? hpst_pkg::PCT_MAX[7:0]
                                                                    : pct_reg[7:0];
                    out_calib_next  = calib_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hpst_pkg::ST_IDLE;
            last_ts_reg   <= 32'd0;
            prev_reg      <= 32'd0;
            cur_reg       <= 32'd0;
            slice_reg     <= hpst_pkg::SLICE_RESET;
            stable_reg    <= 1'b0;
            confirm_reg   <= 8'd0;
            first_reg     <= 1'b1;
            rpm_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_ts_reg   <= last_ts_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            slice_reg     <= slice_next;
            stable_reg    <= stable_next;
            confirm_reg   <= confirm_next;
            first_reg     <= first_next;
            rpm_reg       <= rpm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pct_reg        <= pct_next;
        calib_reg      <= calib_next;
        prev_eff_reg   <= prev_eff_next;
        diff_reg       <= diff_next;
        mean_reg       <= mean_next;
        acc_reg        <= acc_next;
        out_period_reg <= out_period_next;
        out_slice_reg  <= out_slice_next;
        out_stable_reg <= out_stable_next;
        out_rpm_reg    <= out_rpm_next;
        out_pct_reg    <= out_pct_next;
        out_calib_reg  <= out_calib_next;
    end

    assign out_valid      = out_valid_reg;
    assign period_micros  = out_period_reg;
    assign slice_micros   = out_slice_reg;
    assign is_stable      = out_stable_reg;
    assign speed_rpm      = out_rpm_reg;
    assign change_percent = out_pct_reg;
    assign calibrating    = out_calib_reg;

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: hall period stability tracker
// Feeds hall-edge timer captures with random gaps and output stalls. Each
// result word is predicted by a behavioral tachometer with its own copy of
// the tracking state and setup registers, then compared field by field.
// ----------------------------------------------------------------------------
module testbench;

    localparam int                 CYCLE_LIMIT  = 1000000;
    localparam int                 DRAIN_CYCLES = 200;
    localparam int                 RAND_PHASES  = 6;
    localparam int                 PHASE_ITEMS  = 92;
    localparam hpst_pkg::cfg_idx_t REG_SPARE_LO = 3'd5;
    localparam hpst_pkg::cfg_idx_t REG_SPARE_HI = 3'd7;

    typedef struct {
        logic [31:0] period;
        logic [31:0] slice;
        logic        stable;
        logic [15:0] rpm;
        logic [7:0]  pct;
        logic        calib;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] timer_count = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] period_micros;
    logic [31:0] slice_micros;
    logic        is_stable;
    logic [15:0] speed_rpm;
    logic [7:0]  change_percent;
    logic        calibrating;

    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    hpst_pkg::cfg_idx_t cfg_index = hpst_pkg::REG_TICKS_PER_MICRO;
    logic [15:0]        cfg_data = '0;

    // tachometer setup and tracking state as seen by the predictor
    logic [15:0] m_tpm;
    logic [7:0]  m_stable_pct;
    logic [7:0]  m_confirm_need;
    logic [7:0]  m_unstable_pct;
    logic [15:0] m_slices;
    logic [31:0] last_stamp;
    logic [31:0] prev_period;
    logic [31:0] cur_period;
    logic [31:0] slice_time;
    logic        stable_now;
    logic [7:0]  confirm_run;
    logic        awaiting_first;

    logic [31:0] stamp_queue[$];
    reading_t    expected_readings[$];
    logic [31:0] next_stamp = '0;
    int unsigned in_odds = 0;
    int unsigned out_odds = 0;
    int          in_gap = 0;
    int          out_hold = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    hall_period_stability_tracker u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .timer_count    (timer_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .period_micros  (period_micros),
        .slice_micros   (slice_micros),
        .is_stable      (is_stable),
        .speed_rpm      (speed_rpm),
        .change_percent (change_percent),
        .calibrating    (calibrating),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one hall edge: update tracking state, queue the expected result word
    task automatic track_edge(input logic [31:0] stamp);
        reading_t    r;
        logic [31:0] ticks;
        logic [31:0] divisor;
        logic [31:0] diff;
        logic [31:0] mean;
        logic [32:0] sum;
        logic [63:0] change;
        logic [63:0] rpm;
        change  = '0;
        r.calib = 1'b0;
        if (awaiting_first)
        begin
            last_stamp     = stamp;
            awaiting_first = 1'b0;
            r.calib        = 1'b1;
        end
        else
        begin
            ticks      = stamp - last_stamp;
            divisor    = (m_tpm == 16'd0) ? 32'd1 : {16'd0, m_tpm};
            last_stamp = stamp;
            cur_period = ticks / divisor;
            if (prev_period == 32'd0)
                prev_period = cur_period;
            diff = (cur_period > prev_period) ? cur_period - prev_period
                                              : prev_period - cur_period;
            sum  = {1'b0, cur_period} + {1'b0, prev_period};
            mean = sum[32:1];
            if (mean != 32'd0)
                change = ({32'd0, diff} * 64'd100 + {33'd0, mean[31:1]}) / {32'd0, mean};
            prev_period = cur_period;

            // decisions use the unsaturated change
            if (change <= {56'd0, m_stable_pct})
            begin
                if (confirm_run < m_confirm_need)
                    confirm_run = confirm_run + 8'd1;
                if (confirm_run >= m_confirm_need)
                    stable_now = 1'b1;
            end
            else if (change > {56'd0, m_unstable_pct})
            begin
                stable_now  = 1'b0;
                confirm_run = 8'd0;
            end

            if (stable_now && cur_period != 32'd0)
            begin
                slice_time = cur_period / ((m_slices == 16'd0) ? 32'd1 : {16'd0, m_slices});
                if (slice_time == 32'd0)
                    slice_time = 32'd1;
            end
        end
        rpm = (cur_period == 32'd0) ? 64'd0
            : {38'd0, hpst_pkg::RPM_NUMERATOR} / {32'd0, cur_period};
        r.period = cur_period;
        r.slice  = slice_time;
        r.stable = stable_now;
        r.rpm    = (rpm > {48'd0, hpst_pkg::RPM_MAX}) ? hpst_pkg::RPM_MAX : rpm[15:0];
        r.pct    = (change > {55'd0, hpst_pkg::PCT_MAX}) ? hpst_pkg::PCT_MAX[7:0]
                                                         : change[7:0];
        expected_readings.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reading();
        reading_t want;
        if (expected_readings.size() == 0)
        begin
            $error("result word with no edge pending: period_micros %0d", period_micros);
            mismatches++;
        end
        else
        begin
            want = expected_readings.pop_front();
            check_field("period_micros", want.period, period_micros);
            check_field("slice_micros", want.slice, slice_micros);
            check_field("is_stable", {31'd0, want.stable}, {31'd0, is_stable});
            check_field("speed_rpm", {16'd0, want.rpm}, {16'd0, speed_rpm});
            check_field("change_percent", {24'd0, want.pct}, {24'd0, change_percent});
            check_field("calibrating", {31'd0, want.calib}, {31'd0, calibrating});
        end
    endtask

    // input side: hold a word until taken, then gap or present the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            timer_count <= '0;
            in_gap      <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                track_edge(timer_count);
            if (!in_valid || !in_stall)
            begin
                if (in_gap != 0)
                begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (in_odds != 0 && $urandom_range(1, in_odds) == 1)
                begin
                    in_gap   <= $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end
                else if (stamp_queue.size() != 0)
                begin
                    in_valid    <= 1'b1;
                    timer_count <= stamp_queue.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: check taken words, stall in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_hold  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_reading();
            if (out_hold != 0)
            begin
                out_hold  <= out_hold - 1;
                out_stall <= 1'b1;
            end
            else if (out_odds != 0 && $urandom_range(1, out_odds) == 1)
            begin
                out_hold  <= $urandom_range(0, 15);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // caller sits at a clock edge; caller lowers cfg_valid after the batch
    task automatic write_reg(input hpst_pkg::cfg_idx_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            hpst_pkg::REG_TICKS_PER_MICRO:  m_tpm          = data;
            hpst_pkg::REG_STABLE_PERCENT:   m_stable_pct   = data[7:0];
            hpst_pkg::REG_CONFIRM_NEEDED:   m_confirm_need = data[7:0];
            hpst_pkg::REG_UNSTABLE_PERCENT: m_unstable_pct = data[7:0];
            hpst_pkg::REG_ANGLE_SLICES:     m_slices       = data;
            default: ;
        endcase
    endtask

    task automatic load_setup(input bit extreme);
        logic [15:0] tpm;
        logic [15:0] slices;
        logic [7:0]  stab;
        logic [7:0]  need;
        logic [7:0]  unstab;
        if (extreme)
        begin
            tpm    = 16'hFFFF;
            slices = 16'hFFFF;
            stab   = 8'd0;
            need   = 8'hFF;
            unstab = 8'd0;
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:       tpm = 16'd1;
                1:       tpm = hpst_pkg::TPM_RESET;
                2:       tpm = 16'($urandom_range(1, 65535));
                default: tpm = 16'hFFFF;
            endcase
            stab = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 200))
                                               : 8'($urandom_range(0, 12));
            need = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 8));
            unstab = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 200))
                   : 8'($urandom_range(stab, (stab > 170) ? 200 : stab + 30));
            case ($urandom_range(0, 3))
                0:       slices = 16'd1;
                1:       slices = hpst_pkg::SLICES_RESET;
                2:       slices = 16'($urandom_range(1, 65535));
                default: slices = 16'hFFFF;
            endcase
        end
        // upper byte of the 8-bit registers carries junk
        write_reg(hpst_pkg::REG_TICKS_PER_MICRO, tpm);
        write_reg(hpst_pkg::REG_STABLE_PERCENT, {8'($urandom()), stab});
        write_reg(hpst_pkg::REG_CONFIRM_NEEDED, {8'($urandom()), need});
        write_reg(hpst_pkg::REG_UNSTABLE_PERCENT, {8'($urandom()), unstab});
        write_reg(hpst_pkg::REG_ANGLE_SLICES, slices);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] tick_scale();
        tick_scale = (m_tpm == 16'd0) ? 64'd1 : {48'd0, m_tpm};
    endfunction

    task automatic push_delta(input logic [31:0] delta);
        next_stamp = next_stamp + delta;
        stamp_queue.push_back(next_stamp);
    endtask

    // delta for a period in us plus a sub-microsecond remainder
    task automatic push_period(input logic [63:0] per);
        logic [63:0] delta;
        delta = per * tick_scale() + 64'($urandom_range(0, 32'(tick_scale()) - 1));
        if (delta > 64'hFFFF_FFFF)
            delta = 64'hFFFF_FFFF;
        push_delta(delta[31:0]);
    endtask

    // runs of near-constant speed with random content, plus noise captures
    task automatic gen_edges(input int count);
        int          made;
        int          run_len;
        int unsigned jit;
        logic [63:0] cap;
        logic [63:0] hi;
        logic [63:0] base;
        logic [63:0] span;
        logic [63:0] wide;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                next_stamp = $urandom();
                stamp_queue.push_back(next_stamp);
                made++;
            end
            else
            begin
                cap = 64'hFFFF_FFFF / tick_scale();
                hi  = (cap < 64'd2000000) ? cap : 64'd2000000;
                case ($urandom_range(0, 7))
                    0:       base = 64'($urandom_range(0, 12));
                    1:       base = 64'($urandom_range(32'(cap / 2), 32'(cap)));
                    default: base = 64'($urandom_range((hi < 64'd100) ? 0 : 100, 32'(hi)));
                endcase
                if (base > cap)
                    base = cap;
                run_len = $urandom_range(3, 12);
                jit     = $urandom_range(0, 2);
                repeat (run_len)
                begin
                    wide = base;
                    if (jit != 0)
                    begin
                        span = (base * ((jit == 1) ? 64'd1 : 64'd6)) / 64'd200;
                        wide = base + 64'($urandom_range(0, 32'(2 * span))) - span;
                    end
                    if (wide > cap)
                        wide = cap;
                    push_period(wide);
                    made++;
                    if ($urandom_range(0, 15) == 0)
                        base = $urandom_range(0, 1) ? ((base * 2 > cap) ? cap : base * 2)
                                                    : base / 2;
                end
            end
        end
    endtask

    // checked at the falling edge, once the rising edge's updates have settled
    task automatic drain();
        do
            @(negedge clk);
        while (stamp_queue.size() != 0 || in_valid || expected_readings.size() != 0);
    endtask

    initial
    begin
        m_tpm          = hpst_pkg::TPM_RESET;
        m_stable_pct   = hpst_pkg::STABLE_RESET;
        m_confirm_need = hpst_pkg::CONFIRM_RESET;
        m_unstable_pct = hpst_pkg::UNSTABLE_RESET;
        m_slices       = hpst_pkg::SLICES_RESET;
        last_stamp     = '0;
        prev_period    = '0;
        cur_period     = '0;
        slice_time     = hpst_pkg::SLICE_RESET;
        stable_now     = 1'b0;
        confirm_run    = '0;
        awaiting_first = 1'b1;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // default setup: calibration word at the top of the count, then a
        // one-tick period of zero, settle, mid change, big change, change
        // above 200 percent, full-range tick difference, speed saturation
        in_odds  = 3;
        out_odds = 3;
        next_stamp = 32'hFFFF_FFFF;
        stamp_queue.push_back(next_stamp);
        push_delta(32'd1);
        repeat (5) push_period(64'd1000);
        push_period(64'd1050);
        push_period(64'd2000);
        push_period(64'd3);
        push_delta(32'd100);
        push_delta(32'hFFFF_FFFF);
        push_period(64'd1);
        drain();

        // zero ticks per us and zero slices act as one; zero confirm count
        write_reg(hpst_pkg::REG_TICKS_PER_MICRO, 16'd0);
        write_reg(hpst_pkg::REG_ANGLE_SLICES, 16'd0);
        write_reg(hpst_pkg::REG_CONFIRM_NEEDED, {8'hA5, 8'd0});
        write_reg(hpst_pkg::REG_STABLE_PERCENT, {8'h5A, 8'd200});
        write_reg(hpst_pkg::REG_UNSTABLE_PERCENT, {8'hFF, 8'd200});
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'h0F0F);
        cfg_valid <= 1'b0;
        push_delta(32'd5000);
        push_delta(32'd5000);
        push_delta(32'd0);
        push_delta(32'd3);
        push_delta(32'd0);
        push_delta(32'd7000);
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            load_setup(ph == 0);
            in_odds  = (ph == 1 || ph == RAND_PHASES - 1) ? 0 : $urandom_range(2, 6);
            out_odds = (ph == 2 || ph == RAND_PHASES - 1) ? 0 : $urandom_range(2, 6);
            gen_edges(PHASE_ITEMS);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
